// ----- rtl/core/albt_pkg.sv -----
// Shared types, register codes and fixed-point constants of the audio level and beat tracker.
// Depends on nothing; four RTL files take names by scope and the testbench imports them.
package albt_pkg;

  typedef struct packed {
    logic [11:0] amp;
    logic [31:0] tm;
  } job_t;

  typedef struct packed {
    logic [11:0] noise_floor;
    logic [11:0] full_scale_level;
    logic [9:0]  beat_ratio;
    logic        auto_gain_enable;
  } cfg_t;

  typedef struct packed {
    logic [11:0] level;
    logic [11:0] peak;
    logic [11:0] average;
    logic [6:0]  bass;
    logic [6:0]  mid;
    logic [6:0]  treble;
    logic        beat;
    logic [11:0] bpm;
    logic [18:0] gain;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LVL, S_PK, S_LA, S_LA2, S_BS, S_BS2, S_MD, S_MD2, S_BE, S_BE2, S_BE3,
    S_BT, S_BT2, S_BPM, S_AG0, S_AG1, S_AG2, S_AG3, S_AG4, S_B1, S_B2, S_B3, S_B4,
    S_B5, S_B6, S_OUT
  } seq_state_t;

  localparam logic [1:0] REG_NOISE_FLOOR = 2'd0;
  localparam logic [1:0] REG_FULL_SCALE  = 2'd1;
  localparam logic [1:0] REG_BEAT_RATIO  = 2'd2;
  localparam logic [1:0] REG_AUTO_GAIN   = 2'd3;

  localparam logic [11:0] NOISE_FLOOR_RST = 12'd50;
  localparam logic [11:0] FULL_SCALE_RST  = 12'd2048;
  localparam logic [9:0]  BEAT_RATIO_RST  = 10'd384;

  localparam logic [16:0] K_PEAK_DECAY = 17'd64225;
  localparam logic [16:0] K_AVG_KEEP   = 17'd62259;
  localparam logic [16:0] K_AVG_TAKE   = 17'd3277;
  localparam logic [16:0] K_MID_KEEP   = 17'd52429;
  localparam logic [16:0] K_MID_TAKE   = 17'd13107;
  localparam logic [16:0] K_BEA_KEEP   = 17'd64225;
  localparam logic [16:0] K_BEA_TAKE   = 17'd1311;
  localparam logic [16:0] K_LP_DECAY   = 17'd65470;
  localparam logic [16:0] K_LIM_LO     = 17'd26214;
  localparam logic [16:0] K_LIM_HI     = 17'd52429;
  localparam logic [16:0] K_GAIN_UP    = 17'd68813;
  localparam logic [16:0] K_GAIN_DN    = 17'd62259;
  localparam logic [16:0] K_BASS_BAND  = 17'd78643;
  localparam logic [16:0] K_TREB_BAND  = 17'd98304;

  localparam logic [18:0] GAIN_ONE  = 19'd65536;
  localparam logic [19:0] GAIN_MIN  = 20'd32768;
  localparam logic [19:0] GAIN_MAX  = 20'd327680;
  localparam logic [14:0] LEVEL_MAX = 15'd2048;
  localparam logic [27:0] LP_FLOOR  = 28'd655360;

  localparam logic [31:0] REFRACT_MS  = 32'd150;
  localparam logic [31:0] IV_MIN_MS   = 32'd200;
  localparam logic [31:0] IV_MAX_MS   = 32'd2000;
  localparam logic [31:0] GAIN_PER_MS = 32'd500;
  localparam int          MINUTE_MS   = 60000;
  localparam logic [6:0]  BAND_FULL   = 7'd100;
  localparam logic [11:0] BPM_MAX     = 12'd4095;

endpackage

// ----- rtl/core/albt_if.sv -----
// Valid/ready channel interfaces for input items and window results.
// Depends on nothing.
interface albt_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [11:0] sample;
  modport source(output valid, cmd, sample, input ready);
  modport sink(input valid, cmd, sample, output ready);
endinterface

interface albt_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] level;
  logic [11:0] peak;
  logic [11:0] average;
  logic [6:0]  bass;
  logic [6:0]  mid;
  logic [6:0]  treble;
  logic        beat;
  logic [11:0] bpm;
  logic [18:0] gain;
  modport source(output valid, level, peak, average, bass, mid, treble, beat, bpm, gain,
                 input ready);
  modport sink(input valid, level, peak, average, bass, mid, treble, beat, bpm, gain,
               output ready);
endinterface

// ----- rtl/core/albt_front.sv -----
// Front end: accepts samples and ticks, keeps the millisecond clock and the window extremes.
// Depends on albt_pkg and albt_in_if; emits one job per finished window.
module albt_front #(
  parameter int WINDOW_SAMPLES = 16
) (
  input  logic             clk,
  input  logic             rst,
  albt_in_if.sink          in_ch,
  input  logic             full,
  output logic             push,
  output albt_pkg::job_t   job
);
  localparam int CNT_W = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;

  logic [CNT_W-1:0] count;
  logic [11:0]      wmin, wmax, nmin, nmax;
  logic [31:0]      tm;
  logic             acc, last;

  assign in_ch.ready = !full;
  assign acc  = in_ch.valid && in_ch.ready;
  assign last = (count == CNT_W'(WINDOW_SAMPLES - 1));
  assign nmax = (in_ch.sample > wmax) ? in_ch.sample : wmax;
  assign nmin = (in_ch.sample < wmin) ? in_ch.sample : wmin;
  assign push = acc && !in_ch.cmd && last;
  assign job.amp = (nmax >= nmin) ? nmax - nmin : 12'd0;
  assign job.tm  = tm;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wmin  <= 12'hFFF;
      wmax  <= 12'd0;
      tm    <= 32'd0;
    end else if (acc) begin
      if (in_ch.cmd) begin
        tm <= tm + 32'd1;
      end else if (last) begin
        count <= '0;
        wmin  <= 12'hFFF;
        wmax  <= 12'd0;
      end else begin
        count <= count + CNT_W'(1);
        wmin  <= nmin;
        wmax  <= nmax;
      end
    end
  end
endmodule

// ----- rtl/core/albt_fifo.sv -----
// Two-entry job queue between the front end and the window sequencer.
// Depends on albt_pkg for the job type.
module albt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  albt_pkg::job_t din,
  input  logic           pop,
  output albt_pkg::job_t dout,
  output logic           full,
  output logic           empty
);
  albt_pkg::job_t mem [2];
  logic           wp, rp;
  logic [1:0]     cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

// ----- rtl/core/albt_div.sv -----
// Restoring divider, one quotient bit per cycle; quotient held until the next start.
// Depends on nothing.
module albt_div #(
  parameter int NW = 21,
  parameter int DW = 15
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem, d;
  logic [DW:0]   trial;
  logic [CW-1:0] cnt;
  logic          run;

  assign trial = {rem, quo[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(NW);
    end else if (run) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      d   <= den;
    end else if (run) begin
      if (trial >= {1'b0, d}) begin
        rem <= DW'(trial - {1'b0, d});
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end
endmodule

// ----- rtl/core/albt_back.sv -----
// Window sequencer: level, filters, beat and BPM, auto gain and band scaling over a shared
// multiplier and divider. Depends on albt_pkg, albt_out_if and albt_div.
module albt_back #(
  parameter int HISTORY_DEPTH = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  albt_pkg::cfg_t cfg,
  input  albt_pkg::job_t job,
  input  logic           empty,
  output logic           pop,
  albt_out_if.source     out_ch
);
  localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W   = $clog2(HISTORY_DEPTH * 2000);
  localparam int BPM_W   = $clog2(albt_pkg::MINUTE_MS * HISTORY_DEPTH + 1);
  localparam int NW      = (BPM_W > 20) ? BPM_W : 20;
  localparam int DW      = (SUM_W > 12) ? SUM_W : 12;
  localparam logic [NW-1:0] BPM_NUM = NW'(albt_pkg::MINUTE_MS * HISTORY_DEPTH);

  albt_pkg::seq_state_t state, state_next;
  albt_pkg::res_t       res;

  logic [11:0] amp_r, amp2, lvl, peak_hold, fs;
  logic [31:0] tm_r, last_beat, last_gain, beat_dt, gain_dt;
  logic [27:0] la, bass_f, mid_f, bea, lp, tq;
  logic [45:0] acc, sum46;
  logic [44:0] prod, lim_lo;
  logic [27:0] mul_a;
  logic [16:0] mul_b;
  logic [18:0] gain_v;
  logic [19:0] ng;
  logic [10:0] hist [HISTORY_DEPTH];
  logic [SLOT_W-1:0] slot;
  logic [SUM_W-1:0]  isum, sum_new;
  logic [11:0] bpm_v;
  logic [6:0]  bass_b, mid_b, treb_b, band_q;
  logic        beat_seen, beat_r, ov, beat_hit, iv_ok, ag_up, ag_dn, gain_due;
  logic [14:0] lvl_c;
  logic        div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den;

  albt_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  assign amp2    = (amp_r < cfg.noise_floor) ? 12'd0 : amp_r - cfg.noise_floor;
  assign fs      = (cfg.full_scale_level == 12'd0) ? 12'd1 : cfg.full_scale_level;
  assign lvl_c   = (prod[30:16] > albt_pkg::LEVEL_MAX) ? albt_pkg::LEVEL_MAX : prod[30:16];
  assign sum46   = acc + {1'b0, prod};
  assign beat_dt = tm_r - last_beat;
  assign gain_dt = tm_r - last_gain;
  assign beat_hit = ({9'd0, bass_f, 8'd0} > prod) && (beat_dt > albt_pkg::REFRACT_MS);
  assign iv_ok   = beat_seen && (beat_dt > albt_pkg::IV_MIN_MS) && (beat_dt < albt_pkg::IV_MAX_MS);
  assign sum_new = isum - SUM_W'(hist[slot]) + SUM_W'(beat_dt[10:0]);
  assign ag_up   = (lp > albt_pkg::LP_FLOOR) && ({17'd0, lp} < lim_lo);
  assign ag_dn   = ({17'd0, lp} > prod);
  assign gain_due = gain_dt > albt_pkg::GAIN_PER_MS;
  assign ng      = prod[35:16];
  assign band_q  = (div_quo > NW'(albt_pkg::BAND_FULL)) ? albt_pkg::BAND_FULL : div_quo[6:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      albt_pkg::S_IDLE: if (!empty) state_next = albt_pkg::S_LVL;
      albt_pkg::S_LVL:  state_next = albt_pkg::S_PK;
      albt_pkg::S_PK:   state_next = albt_pkg::S_LA;
      albt_pkg::S_LA:   state_next = albt_pkg::S_LA2;
      albt_pkg::S_LA2:  state_next = albt_pkg::S_BS;
      albt_pkg::S_BS:   state_next = albt_pkg::S_BS2;
      albt_pkg::S_BS2:  state_next = albt_pkg::S_MD;
      albt_pkg::S_MD:   state_next = albt_pkg::S_MD2;
      albt_pkg::S_MD2:  state_next = albt_pkg::S_BE;
      albt_pkg::S_BE:   state_next = albt_pkg::S_BE2;
      albt_pkg::S_BE2:  state_next = albt_pkg::S_BE3;
      albt_pkg::S_BE3:  state_next = albt_pkg::S_BT;
      albt_pkg::S_BT:   state_next = albt_pkg::S_BT2;
      albt_pkg::S_BT2:  state_next = (beat_hit && iv_ok) ? albt_pkg::S_BPM : albt_pkg::S_AG0;
      albt_pkg::S_BPM:  if (div_done) state_next = albt_pkg::S_AG0;
      albt_pkg::S_AG0:  state_next = cfg.auto_gain_enable ? albt_pkg::S_AG1 : albt_pkg::S_B1;
      albt_pkg::S_AG1:  state_next = albt_pkg::S_AG2;
      albt_pkg::S_AG2:  state_next = albt_pkg::S_AG3;
      albt_pkg::S_AG3:  state_next = (gain_due && (ag_up || ag_dn)) ? albt_pkg::S_AG4
                                                                    : albt_pkg::S_B1;
      albt_pkg::S_AG4:  state_next = albt_pkg::S_B1;
      albt_pkg::S_B1:   state_next = albt_pkg::S_B2;
      albt_pkg::S_B2:   state_next = albt_pkg::S_B3;
      albt_pkg::S_B3:   if (div_done) state_next = albt_pkg::S_B4;
      albt_pkg::S_B4:   if (div_done) state_next = albt_pkg::S_B5;
      albt_pkg::S_B5:   state_next = albt_pkg::S_B6;
      albt_pkg::S_B6:   if (div_done) state_next = albt_pkg::S_OUT;
      albt_pkg::S_OUT:  if (!ov || out_ch.ready) state_next = albt_pkg::S_IDLE;
      default:          state_next = albt_pkg::S_IDLE;
    endcase
  end

  // multiplier operands, divider launch, queue pop
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DW'(fs);
    pop       = 1'b0;
    case (state)
      albt_pkg::S_IDLE: pop = !empty;
      albt_pkg::S_LVL:  begin mul_a = 28'(gain_v);    mul_b = 17'(amp2); end
      albt_pkg::S_PK:   begin mul_a = 28'(peak_hold); mul_b = albt_pkg::K_PEAK_DECAY; end
      albt_pkg::S_LA:   begin mul_a = la;             mul_b = albt_pkg::K_AVG_KEEP; end
      albt_pkg::S_LA2:  begin mul_a = 28'(lvl);       mul_b = albt_pkg::K_AVG_TAKE; end
      albt_pkg::S_BS:   begin mul_a = bass_f;         mul_b = albt_pkg::K_AVG_KEEP; end
      albt_pkg::S_BS2:  begin mul_a = 28'(lvl);       mul_b = albt_pkg::K_AVG_TAKE; end
      albt_pkg::S_MD:   begin mul_a = mid_f;          mul_b = albt_pkg::K_MID_KEEP; end
      albt_pkg::S_MD2:  begin mul_a = 28'(lvl);       mul_b = albt_pkg::K_MID_TAKE; end
      albt_pkg::S_BE:   begin mul_a = bea;            mul_b = albt_pkg::K_BEA_KEEP; end
      albt_pkg::S_BE2:  begin mul_a = bass_f;         mul_b = albt_pkg::K_BEA_TAKE; end
      albt_pkg::S_BT:   begin mul_a = bea;            mul_b = 17'(cfg.beat_ratio); end
      albt_pkg::S_BT2:  begin
        div_start = beat_hit && iv_ok;
        div_num   = BPM_NUM;
        div_den   = DW'(sum_new);
      end
      albt_pkg::S_AG0:  begin mul_a = lp;             mul_b = albt_pkg::K_LP_DECAY; end
      albt_pkg::S_AG1:  begin mul_a = 28'(fs);        mul_b = albt_pkg::K_LIM_LO; end
      albt_pkg::S_AG2:  begin mul_a = 28'(fs);        mul_b = albt_pkg::K_LIM_HI; end
      albt_pkg::S_AG3:  begin
        mul_a = 28'(gain_v);
        mul_b = ag_up ? albt_pkg::K_GAIN_UP : albt_pkg::K_GAIN_DN;
      end
      albt_pkg::S_B1:   begin mul_a = bass_f;         mul_b = albt_pkg::K_BASS_BAND; end
      albt_pkg::S_B2:   begin
        div_start = 1'b1;
        div_num   = NW'(prod[44:32] * 7'd100);
      end
      albt_pkg::S_B3:   begin
        div_start = div_done;
        div_num   = NW'(mid_f[27:16] * 7'd100);
      end
      albt_pkg::S_B4:   begin mul_a = tq;             mul_b = albt_pkg::K_TREB_BAND; end
      albt_pkg::S_B5:   begin
        div_start = 1'b1;
        div_num   = NW'(prod[44:32] * 7'd100);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= albt_pkg::S_IDLE;
      ov        <= 1'b0;
      peak_hold <= 12'd0;
      la        <= '0;
      bass_f    <= '0;
      mid_f     <= '0;
      bea       <= '0;
      lp        <= '0;
      gain_v    <= albt_pkg::GAIN_ONE;
      last_beat <= 32'd0;
      last_gain <= 32'd0;
      beat_seen <= 1'b0;
      slot      <= '0;
      isum      <= '0;
      bpm_v     <= 12'd0;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] <= 11'd0;
    end else begin
      state <= state_next;
      if (out_ch.ready) ov <= 1'b0;
      case (state)
        albt_pkg::S_IDLE: if (!empty) begin
          amp_r <= job.amp;
          tm_r  <= job.tm;
        end
        albt_pkg::S_PK:  lvl <= lvl_c[11:0];
        albt_pkg::S_LA:  peak_hold <= (lvl > peak_hold) ? lvl : prod[27:16];
        albt_pkg::S_LA2: acc <= 46'(prod[44:16]);
        albt_pkg::S_BS:  la <= acc[27:0] + prod[27:0];
        albt_pkg::S_BS2: acc <= 46'(prod[44:16]);
        albt_pkg::S_MD:  bass_f <= acc[27:0] + prod[27:0];
        albt_pkg::S_MD2: acc <= 46'(prod[44:16]);
        albt_pkg::S_BE:  begin
          mid_f <= acc[27:0] + prod[27:0];
          tq    <= ({lvl, 16'd0} > la) ? {lvl, 16'd0} - la : la - {lvl, 16'd0};
        end
        albt_pkg::S_BE2: acc <= {1'b0, prod};
        albt_pkg::S_BE3: bea <= sum46[43:16];
        albt_pkg::S_BT2: begin
          beat_r <= beat_hit;
          if (beat_hit) begin
            last_beat <= tm_r;
            beat_seen <= 1'b1;
            if (iv_ok) begin
              hist[slot] <= beat_dt[10:0];
              isum       <= sum_new;
              slot       <= (slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot + SLOT_W'(1);
            end
          end
        end
        albt_pkg::S_BPM: if (div_done) begin
          bpm_v <= (div_quo > NW'(albt_pkg::BPM_MAX)) ? albt_pkg::BPM_MAX : div_quo[11:0];
        end
        albt_pkg::S_AG1: lp <= ({peak_hold, 16'd0} > lp) ? {peak_hold, 16'd0} : prod[43:16];
        albt_pkg::S_AG2: lim_lo <= prod;
        albt_pkg::S_AG3: if (gain_due) last_gain <= tm_r;
        albt_pkg::S_AG4: begin
          if (ng < albt_pkg::GAIN_MIN)      gain_v <= albt_pkg::GAIN_MIN[18:0];
          else if (ng > albt_pkg::GAIN_MAX) gain_v <= albt_pkg::GAIN_MAX[18:0];
          else                              gain_v <= ng[18:0];
        end
        albt_pkg::S_B3:  if (div_done) bass_b <= band_q;
        albt_pkg::S_B4:  if (div_done) mid_b <= band_q;
        albt_pkg::S_B6:  if (div_done) treb_b <= band_q;
        albt_pkg::S_OUT: if (!ov || out_ch.ready) begin
          ov          <= 1'b1;
          res.level   <= lvl;
          res.peak    <= peak_hold;
          res.average <= la[27:16];
          res.bass    <= bass_b;
          res.mid     <= mid_b;
          res.treble  <= treb_b;
          res.beat    <= beat_r;
          res.bpm     <= bpm_v;
          res.gain    <= gain_v;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid   = ov;
  assign out_ch.level   = res.level;
  assign out_ch.peak    = res.peak;
  assign out_ch.average = res.average;
  assign out_ch.bass    = res.bass;
  assign out_ch.mid     = res.mid;
  assign out_ch.treble  = res.treble;
  assign out_ch.beat    = res.beat;
  assign out_ch.bpm     = res.bpm;
  assign out_ch.gain    = res.gain;
endmodule

// ----- rtl/core/audio_level_beat_tracker.sv -----
// Audio level and beat tracker. The front end gathers each window; its result follows
// the window's last sample through the window sequencer, whose pace is set by the shared
// multiplier and the bit-serial divider, which serves the BPM and band divisions.
// Sustained rate: one window per sequencer pass; input stalls while the job queue is full.
// Synchronous active-high reset restores the configuration and all tracker state at once.
module audio_level_beat_tracker #(
  parameter int WINDOW_SAMPLES = 16,
  parameter int HISTORY_DEPTH  = 10
) (
  input  logic        clk,
  input  logic        rst,
  albt_in_if.sink     in_ch,
  albt_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  albt_pkg::cfg_t cfg;
  albt_pkg::job_t job_in, job_out;
  logic           push, pop, full, empty, wr;

  // Configuration: written on the access phase, read back combinationally.
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.noise_floor      <= albt_pkg::NOISE_FLOOR_RST;
      cfg.full_scale_level <= albt_pkg::FULL_SCALE_RST;
      cfg.beat_ratio       <= albt_pkg::BEAT_RATIO_RST;
      cfg.auto_gain_enable <= 1'b0;
    end else if (wr) begin
      case (paddr[3:2])
        albt_pkg::REG_NOISE_FLOOR: cfg.noise_floor      <= pwdata[11:0];
        albt_pkg::REG_FULL_SCALE:  cfg.full_scale_level <= pwdata[11:0];
        albt_pkg::REG_BEAT_RATIO:  cfg.beat_ratio       <= pwdata[9:0];
        albt_pkg::REG_AUTO_GAIN:   cfg.auto_gain_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      albt_pkg::REG_NOISE_FLOOR: prdata = {20'd0, cfg.noise_floor};
      albt_pkg::REG_FULL_SCALE:  prdata = {20'd0, cfg.full_scale_level};
      albt_pkg::REG_BEAT_RATIO:  prdata = {22'd0, cfg.beat_ratio};
      albt_pkg::REG_AUTO_GAIN:   prdata = {31'd0, cfg.auto_gain_enable};
      default:                   prdata = 32'd0;
    endcase
  end

  // Front end: window extremes and millisecond time; hands each window on as a job.
  albt_front #(.WINDOW_SAMPLES(WINDOW_SAMPLES)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .full(full), .push(push), .job(job_in)
  );

  // Hold up to two finished windows so the front end keeps taking samples.
  albt_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .din(job_in), .pop(pop), .dout(job_out),
    .full(full), .empty(empty)
  );

  // Back end: level, filters, beat, BPM, auto gain, bands; result register on the output.
  albt_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .job(job_out), .empty(empty), .pop(pop),
    .out_ch(out_ch)
  );
endmodule

// ----- tb/audio_level_beat_tracker_test.sv -----
// Self-checking testbench for audio_level_beat_tracker: random windows of samples and
// millisecond ticks under handshake pressure, checked against a built-in predictor.
// Depends on albt_pkg, albt_in_if/albt_out_if and the tracker RTL.
module audio_level_beat_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import albt_pkg::*;

  typedef bit [63:0] u64;

  localparam int WINDOW  = 16;
  localparam int HISTORY = 10;
  localparam int LIMIT   = 2000000;

  // Predicts the window results of the tracker and holds those still awaited.
  class beat_scoreboard;
    bit [11:0] noise_floor, full_scale;
    bit [9:0]  ratio;
    bit        agc_on;
    bit [11:0] win_lo, win_hi;
    int        fill;
    bit [31:0] now_ms, beat_ms, gain_ms;
    bit        had_beat;
    bit [11:0] peak_hold;
    u64        lvl_avg, bass_f, mid_f, bass_slow, long_pk;
    u64        gain_q;
    bit [31:0] gaps [HISTORY];
    int        slot;
    bit [31:0] gap_sum, bpm_now;
    res_t      awaited [$];
    int        errors;

    function new();
      noise_floor = NOISE_FLOOR_RST;
      full_scale  = FULL_SCALE_RST;
      ratio       = BEAT_RATIO_RST;
      agc_on      = 0;
      win_lo      = 12'hFFF;
      win_hi      = 0;
      fill        = 0;
      now_ms      = 0;
      beat_ms     = 0;
      gain_ms     = 0;
      had_beat    = 0;
      peak_hold   = 0;
      lvl_avg     = 0;
      bass_f      = 0;
      mid_f       = 0;
      bass_slow   = 0;
      long_pk     = 0;
      gain_q      = GAIN_ONE;
      foreach (gaps[i]) gaps[i] = 0;
      slot        = 0;
      gap_sum     = 0;
      bpm_now     = 0;
      errors      = 0;
    endfunction

    function void set_reg(bit [1:0] idx, bit [31:0] val);
      case (idx)
        REG_NOISE_FLOOR: noise_floor = val[11:0];
        REG_FULL_SCALE:  full_scale  = val[11:0];
        REG_BEAT_RATIO:  ratio       = val[9:0];
        REG_AUTO_GAIN:   agc_on      = val[0];
        default: ;
      endcase
    endfunction

    function u64 blend(u64 old, u64 lvl, u64 keep, u64 take);
      return (old * keep + (lvl << 16) * take) >> 16;
    endfunction

    function u64 to_band(u64 t, u64 fs);
      u64 v;
      v = t * 100 / fs;
      return (v > 100) ? 100 : v;
    endfunction

    // Take one accepted transaction; queue a result when it closes a window.
    function void note(bit is_tick, bit [11:0] s);
      u64 amp, lvl, fs, cur_q, dev_q, pk_q, ng, iv;
      bit beat;
      res_t r;
      beat = 0;
      if (is_tick) begin
        now_ms = now_ms + 1;
        return;
      end
      if (s > win_hi) win_hi = s;
      if (s < win_lo) win_lo = s;
      fill++;
      if (fill < WINDOW) return;
      fill = 0;
      amp = (win_hi >= win_lo) ? u64'(win_hi - win_lo) : 0;
      win_lo = 12'hFFF;
      win_hi = 0;
      amp = (amp < noise_floor) ? 0 : amp - noise_floor;
      lvl = (amp * gain_q) >> 16;
      if (lvl > 2048) lvl = 2048;

      if (lvl > peak_hold) peak_hold = lvl;
      else peak_hold = (u64'(peak_hold) * 64225) >> 16;

      lvl_avg = blend(lvl_avg, lvl, 62259, 3277);
      bass_f  = blend(bass_f, lvl, 62259, 3277);
      mid_f   = blend(mid_f, lvl, 52429, 13107);
      cur_q   = lvl << 16;
      dev_q   = (cur_q > lvl_avg) ? cur_q - lvl_avg : lvl_avg - cur_q;
      fs      = (full_scale == 0) ? 1 : full_scale;

      bass_slow = (bass_slow * 64225 + bass_f * 1311) >> 16;
      if (bass_f * 256 > bass_slow * ratio && (now_ms - beat_ms) > 150) begin
        beat = 1;
        if (had_beat) begin
          iv = now_ms - beat_ms;
          // drop intervals outside the plausible tempo range
          if (iv > 200 && iv < 2000) begin
            gap_sum = gap_sum - gaps[slot] + iv;
            gaps[slot] = iv;
            slot = (slot + 1) % HISTORY;
            if (gap_sum > 0) bpm_now = (60000 * HISTORY / gap_sum > 4095) ? 4095
                                       : 60000 * HISTORY / gap_sum;
          end
        end
        beat_ms  = now_ms;
        had_beat = 1;
      end

      if (agc_on) begin
        pk_q = u64'(peak_hold) << 16;
        if (pk_q > long_pk) long_pk = pk_q;
        else long_pk = (long_pk * 65470) >> 16;
        if ((now_ms - gain_ms) > 500) begin
          ng = gain_q;
          gain_ms = now_ms;
          if (long_pk > (u64'(10) << 16) && long_pk < fs * 26214) ng = (ng * 68813) >> 16;
          else if (long_pk > fs * 52429) ng = (ng * 62259) >> 16;
          if (ng < 32768) ng = 32768;
          if (ng > 327680) ng = 327680;
          gain_q = ng;
        end
      end

      r.level   = lvl[11:0];
      r.peak    = peak_hold;
      r.average = lvl_avg[27:16];
      r.bass    = to_band((bass_f * 78643) >> 32, fs);
      r.mid     = to_band(mid_f >> 16, fs);
      r.treble  = to_band((dev_q * 98304) >> 32, fs);
      r.beat    = beat;
      r.bpm     = bpm_now[11:0];
      r.gain    = gain_q[18:0];
      awaited.push_back(r);
    endfunction

    function void cmp(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
        return;
      end
      want = awaited.pop_front();
      cmp("level", want.level, got.level);
      cmp("peak", want.peak, got.peak);
      cmp("average", want.average, got.average);
      cmp("bass", want.bass, got.bass);
      cmp("mid", want.mid, got.mid);
      cmp("treble", want.treble, got.treble);
      cmp("beat", want.beat, got.beat);
      cmp("bpm", want.bpm, got.bpm);
      cmp("gain", want.gain, got.gain);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  albt_in_if  in_ch();
  albt_out_if out_ch();

  audio_level_beat_tracker i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  beat_scoreboard tracker = new();
  int unsigned    cycles = 0;
  int unsigned    rx_tick = 0;
  int             burst_left = 0;

  initial begin
    in_ch.valid  = 0;
    in_ch.cmd    = 0;
    in_ch.sample = 0;
    out_ch.ready = 0;
  end

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Watchdog: give up well beyond the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("audio_level_beat_tracker_test failed");
      $finish;
    end
  end

  // Receiver: cycle through always-ready, coin-toss, sparse and mostly-ready stalls.
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_tick[11:10])
      2'd0: out_ch.ready <= 1'b1;
      2'd1: out_ch.ready <= $urandom_range(0, 1);
      2'd2: out_ch.ready <= (rx_tick[2:0] == 3'd0);
      default: out_ch.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Check every result transaction at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      tracker.check('{level: out_ch.level, peak: out_ch.peak, average: out_ch.average,
                      bass: out_ch.bass, mid: out_ch.mid, treble: out_ch.treble,
                      beat: out_ch.beat, bpm: out_ch.bpm, gain: out_ch.gain});
    end
  end

  // Offer one transaction; hold valid across a burst, idle between bursts.
  task automatic send(bit is_tick, bit [11:0] s);
    int gap;
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= is_tick;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note(is_tick, s);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // no idling at all during alternate stretches of the run
      gap = cycles[13] ? 0 : $urandom_range(0, 5);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_ticks(int n);
    repeat (n) send(1'b1, 12'($urandom));
  endtask

  // Let every awaited result arrive, then let the design idle before returning.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic reg_write(bit [1:0] idx, bit [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(bit [11:0] nf, bit [11:0] fs, bit [9:0] ratio, bit agc);
    drain();
    reg_write(REG_NOISE_FLOOR, nf);
    reg_write(REG_FULL_SCALE, fs);
    reg_write(REG_BEAT_RATIO, ratio);
    reg_write(REG_AUTO_GAIN, agc);
  endtask

  // One window: quiet bed with occasional loud pulses so the bass filter
  // overshoots its slow average; a few windows are plain noise.
  task automatic window(int max_ticks, int span_lo, int span_hi);
    int span, base, cut;
    bit noisy;
    span  = ($urandom_range(0, 3) == 0) ? $urandom_range(1000, 4095)
                                        : $urandom_range(span_lo, span_hi);
    base  = $urandom_range(0, 4095 - span);
    noisy = ($urandom_range(0, 9) == 0);
    cut   = $urandom_range(0, WINDOW - 1);
    send_ticks($urandom_range(0, max_ticks));
    for (int k = 0; k < WINDOW; k++) begin
      if (k == cut) send_ticks($urandom_range(0, 3));
      send(1'b0, noisy ? 12'($urandom) : 12'(base + $urandom_range(0, span)));
    end
  endtask

  task automatic run_windows(int n, int max_ticks, int span_lo, int span_hi);
    repeat (n) window(max_ticks, span_lo, span_hi);
  endtask

  // Windows with a fixed tick count, steady enough to walk the gain to a clamp.
  task automatic gain_walk(int n, int ticks, int span);
    repeat (n) begin
      send_ticks(ticks);
      for (int k = 0; k < WINDOW; k++) send(1'b0, 12'(1000 + $urandom_range(0, span)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: both sample extremes in one window, then ticks.
    send(1'b0, 12'd0);
    send(1'b0, 12'hFFF);
    for (int k = 0; k < WINDOW - 2; k++) send(1'b0, 12'd2048);
    send_ticks(3);
    run_windows(15, 60, 0, 200);

    configure(12'd0, 12'd4095, 10'd256, 1'b1);
    run_windows(15, 80, 0, 300);

    configure(12'd4095, 12'd1, 10'd1023, 1'b0);
    run_windows(4, 40, 0, 4095);

    // A full scale of zero behaves as one.
    configure(12'd10, 12'd0, 10'd300, 1'b1);
    run_windows(8, 60, 0, 200);

    // Quiet input with auto gain: gain climbs until it clamps high.
    configure(12'd0, 12'd4095, 10'd384, 1'b1);
    gain_walk(40, 510, 40);

    // Loud input against a small full scale: gain falls to its floor.
    configure(12'd0, 12'd200, 10'd384, 1'b1);
    gain_walk(50, 510, 3000);

    configure(12'd30, 12'd2048, 10'd384, 1'b1);
    run_windows(15, 60, 0, 200);

    drain();
    if (tracker.awaited.size() != 0) tracker.errors++;
    if (tracker.errors == 0) begin
      $display("audio_level_beat_tracker_test passed");
    end else begin
      $display("audio_level_beat_tracker_test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/albt_pkg.sv
rtl/core/albt_if.sv
rtl/core/albt_front.sv
rtl/core/albt_fifo.sv
rtl/core/albt_div.sv
rtl/core/albt_back.sv
rtl/core/audio_level_beat_tracker.sv
tb/audio_level_beat_tracker_test.sv
